// File: design/ede_pkg.sv
// ----------------------------------------------------------------------------
// Edit distance engine package
// Shared constants, operation codes, the cell-to-cell transfer type and the
// distance saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ede_pkg;

	// Longest string held; the cell row has one cell per byte of the second string.
	localparam int MAX_LEN = 64;

	// Width of a string length and of a row value (both lie in 0..MAX_LEN).
	localparam int LEN_W = $clog2(MAX_LEN + 1);

	// Address width of the first-string store.
	localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	// Byte width and result width.
	localparam int SYM_W  = 8;
	localparam int DIST_W = 7;
	localparam int DIST_MAX = (1 << DIST_W) - 1;

	// Input operation codes.
	typedef enum logic [1:0] {
		OP_APPEND_FIRST  = 2'd0,
		OP_APPEND_SECOND = 2'd1,
		OP_FINISH        = 2'd2,
		OP_NONE          = 2'd3
	} op_t;

	// One transfer along the cell row: a first-string byte with the row value
	// to its left.
	typedef struct packed {
		logic             vld;
		logic             last;
		logic [SYM_W-1:0] sym;
		logic [LEN_W-1:0] val;
	} cell_flow_t;

	// Clamp a row value to the result width.
	function automatic logic [DIST_W-1:0] sat_dist(input logic [LEN_W-1:0] v);
		logic [DIST_W-1:0] r;
		if (int'(v) > DIST_MAX) begin
			r = DIST_W'(DIST_MAX);
		end else begin
			r = DIST_W'(v);
		end
		return r;
	endfunction

endpackage : ede_pkg

`default_nettype wire

// File: design/edit_distance_engine.sv
// ----------------------------------------------------------------------------
// Edit distance engine
// Levenshtein distance between two byte strings using a systolic cell row.
// ----------------------------------------------------------------------------
// Appends of either string may follow one another back to back. A finish
// with an empty first string presents its result in the cycle right after
// the transfer. Otherwise the first string is streamed from its store
// through the row of MAX_LEN cells, one byte per cycle; the last byte passes
// through the output register of every cell, whatever the length of the
// second string, before the sequencer takes the result into its register.
// The result is shown on distance and overflow for one cycle with done high,
// and cannot be held off; busy stays high until it has gone.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_distance_engine
	import ede_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        op,
	input  wire logic [SYM_W-1:0]  symbol,
	output logic                   busy,
	output logic                   done,
	output logic      [DIST_W-1:0] distance,
	output logic                   overflow
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FEED,
		S_DRAIN,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  len1_q;
	logic [LEN_W-1:0]  len2_q;
	logic              ovf_q;
	logic [LEN_W-1:0]  rd_q;
	logic              done_q;
	logic [DIST_W-1:0] distance_q;
	logic              overflow_q;

	logic              feed_vld_s1;
	logic              feed_last_s1;
	logic [LEN_W-1:0]  feed_val_s1;

	logic              accept;
	op_t               op_in;
	logic              ram_we;
	logic [SYM_W-1:0]  ram_rdata;
	logic              cell_init;
	cell_flow_t        flow [MAX_LEN + 1];
	cell_flow_t        tail;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign op_in  = op_t'(op);

	assign ram_we    = accept && (op_in == OP_APPEND_FIRST) && (int'(len1_q) < MAX_LEN);
	assign cell_init = accept && (op_in == OP_FINISH);

	// First string store.
	ede_ram #(
		.WIDTH(SYM_W),
		.DEPTH(MAX_LEN)
	) u_first_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(len1_q[ADDR_W-1:0]),
		.wdata(symbol),
		.raddr(rd_q[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// Feed stage: row index and last mark line up with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_vld_s1 <= 1'b0;
		end else begin
			feed_vld_s1 <= (state_q == S_FEED);
		end
	end

	always_ff @(posedge clk) begin
		feed_last_s1 <= ((rd_q + LEN_W'(1)) == len1_q);
		feed_val_s1  <= rd_q + LEN_W'(1);
	end

	assign flow[0] = '{vld: feed_vld_s1, last: feed_last_s1, sym: ram_rdata, val: feed_val_s1};

	// Row of cells, one per second-string byte.
	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		ede_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.we      (accept && (op_in == OP_APPEND_SECOND) && (len2_q == LEN_W'(k))),
			.wr_sym  (symbol),
			.init    (cell_init),
			.col     (LEN_W'(k + 1)),
			.active  (len2_q > LEN_W'(k)),
			.flow_in (flow[k]),
			.flow_out(flow[k + 1])
		);
	end

	assign tail = flow[MAX_LEN];

	// Sequencer: string lengths, streaming counter and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len1_q     <= '0;
			len2_q     <= '0;
			ovf_q      <= 1'b0;
			rd_q       <= '0;
			done_q     <= 1'b0;
			distance_q <= '0;
			overflow_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op_in)
							OP_APPEND_FIRST: begin
								if (int'(len1_q) < MAX_LEN) begin
									len1_q <= len1_q + LEN_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_APPEND_SECOND: begin
								if (int'(len2_q) < MAX_LEN) begin
									len2_q <= len2_q + LEN_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_FINISH: begin
								if (len1_q == '0) begin
									done_q     <= 1'b1;
									distance_q <= sat_dist(len2_q);
									overflow_q <= ovf_q;
									len2_q     <= '0;
									ovf_q      <= 1'b0;
									state_q    <= S_EMIT;
								end else begin
									rd_q    <= '0;
									state_q <= S_FEED;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FEED: begin
					rd_q <= rd_q + LEN_W'(1);
					if ((rd_q + LEN_W'(1)) == len1_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (tail.vld && tail.last) begin
						done_q     <= 1'b1;
						distance_q <= sat_dist(tail.val);
						overflow_q <= ovf_q;
						len1_q     <= '0;
						len2_q     <= '0;
						ovf_q      <= 1'b0;
						state_q    <= S_EMIT;
					end
				end
				S_EMIT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign distance = distance_q;
	assign overflow = overflow_q;

`ifndef SYNTHESIS
	// The row output only carries data once streaming of the first string is over.
	a_tail_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> (state_q == S_DRAIN))
		else $error("cell row output outside the drain phase");

	// Both strings and the overflow mark are cleared with every result.
	a_clear_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (len1_q == '0) && (len2_q == '0) && !ovf_q)
		else $error("strings not cleared with the result");

	// String lengths never pass the store depth.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(len1_q) <= MAX_LEN) && (int'(len2_q) <= MAX_LEN))
		else $error("string length beyond store depth");

	// The block only goes idle again right after presenting a result.
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done_q))
		else $error("busy fell without a result transfer");
`endif

endmodule : edit_distance_engine

`default_nettype wire

// File: design/ede_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ede_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule : ede_ram

`default_nettype wire

// File: design/ede_cell.sv
// ----------------------------------------------------------------------------
// Edit distance cell
// Holds one byte of the second string and its column of the running row. Each
// first-string byte passing through updates the column and moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module ede_cell
	import ede_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [SYM_W-1:0] wr_sym,
	input  wire logic             init,
	input  wire logic [LEN_W-1:0] col,
	input  wire logic             active,
	input  wire cell_flow_t       flow_in,
	output cell_flow_t            flow_out
);

	logic [SYM_W-1:0] b_q;
	logic [LEN_W-1:0] d_q;
	logic [LEN_W-1:0] diag_q;
	cell_flow_t       out_q;

	logic [LEN_W:0] up_cost;
	logic [LEN_W:0] left_cost;
	logic [LEN_W:0] diag_cost;
	logic [LEN_W:0] best;

	// Cost of deletion, insertion and substitution or match.
	always_comb begin
		up_cost   = {1'b0, d_q} + (LEN_W + 1)'(1);
		left_cost = {1'b0, flow_in.val} + (LEN_W + 1)'(1);
		diag_cost = {1'b0, diag_q} + (LEN_W + 1)'(flow_in.sym != b_q);
		best = (up_cost < left_cost) ? up_cost : left_cost;
		best = (diag_cost < best) ? diag_cost : best;
	end

	// Byte held by this cell.
	always_ff @(posedge clk) begin
		if (we) begin
			b_q <= wr_sym;
		end
	end

	// Column value, previous left value and the transfer to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else begin
			out_q.vld  <= flow_in.vld;
			out_q.last <= flow_in.last;
			out_q.sym  <= flow_in.sym;
			if (active) begin
				out_q.val <= best[LEN_W-1:0];
			end else begin
				out_q.val <= flow_in.val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			d_q    <= col;
			diag_q <= col - LEN_W'(1);
		end else if (flow_in.vld) begin
			if (active) begin
				d_q <= best[LEN_W-1:0];
			end
			diag_q <= flow_in.val;
		end
	end

	assign flow_out = out_q;

endmodule : ede_cell

`default_nettype wire
